// File: hdl/i2cms_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
// Holds request structs, phase encoding, FIFO entry and status types.
// No dependencies.
package i2cms_pkg;

    // item kinds
    localparam logic [1:0] KIND_POLL  = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_PUSH  = 2'd2;

    // bus commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_TX    = 3'd3;
    localparam logic [2:0] CMD_RCEN  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;

    // halt codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OUT_FULL  = 3'd1;
    localparam logic [2:0] ERR_NO_ACK    = 3'd2;
    localparam logic [2:0] ERR_OUT_EMPTY = 3'd3;
    localparam logic [2:0] ERR_BAD_STATE = 3'd4;
    localparam logic [2:0] ERR_COLLISION = 3'd5;
    localparam logic [2:0] ERR_IN_FULL   = 3'd6;
    localparam logic [2:0] ERR_BAD_FRAME = 3'd7;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_START     = 6'b000010,
        PH_ACK_RCVD  = 6'b000100,
        PH_BYTE_RCVD = 6'b001000,
        PH_ACK_SENT  = 6'b010000,
        PH_STOP      = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] push_byte;
        logic       push_last;
        logic       ack_status;
        logic [7:0] rx_byte;
        logic       write_collision;
        logic       rx_queue_full;
    } evt_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       rx_is_address;
        logic       rx_last;
        logic [2:0] error_code;
        logic       halted;
    } res_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] read_remaining;
        logic       frame_in_progress;
        logic [2:0] halt_error;
    } ctrl_t;

    // FIFO status seen by the step logic
    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;   // count below two
        logic no_frames;
    } fstat_t;

    // FIFO update requested by the step logic
    typedef struct packed {
        logic       push;
        logic       push_last;
        logic [1:0] pop_n;
        logic       frame_dec;
    } fupd_t;

endpackage

// File: hdl/i2c_master_transaction_sequencer.sv
// Top level of the I2C master transaction sequencer: outgoing frame FIFO
// memory, two-stage request pipeline, result register. Uses i2cms_pkg, i2cms_step.
//
//  channel | valid     | stall     | payload | direction
//  --------+-----------+-----------+---------+----------
//  evt     | evt_valid | evt_stall | evt_t   | into block
//  res     | res_valid | res_stall | res_t   | out of block
//
// Each request gives exactly one result, registered through the execute
// stage and the result register; one request is taken every cycle unless
// evt_stall is high. Stage one issues registered FIFO memory reads at head
// and head+1, stage two decides and writes back; a same-cycle push is forwarded.
// Reset clears FIFO pointers, counts, phase and halt code; the memory itself
// is not cleared. evt_stall rises only while a result waits under res_stall.
module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
#(
    parameter int FIFO_DEPTH = 128
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic evt_valid,
    output logic evt_stall,
    input  evt_t evt,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
        adv = (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    // outgoing frame FIFO
    entry_t mem [FIFO_DEPTH];

    logic [AW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg, frames_reg;
    ctrl_t         ctrl_reg;

    // execute stage
    logic   ex_valid_reg;
    evt_t   ex_evt_reg;
    entry_t rd0_reg, rd1_reg, wd_reg;
    logic   fwd0_reg, fwd1_reg;

    // result register
    logic res_valid_reg;
    res_t res_reg;

    logic    fire;
    logic    accept;
    entry_t  e0, e1;
    fstat_t  fst;
    ctrl_t   ctrl_next;
    fupd_t   upd;
    res_t    step_res;
    logic [AW-1:0] head_adv1, head_adv2, head_next, rd_addr0, rd_addr1;
    logic [CW-1:0] count_next, frames_next;
    logic    wr_en;
    entry_t  wr_data;

    assign fire      = ex_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall = ex_valid_reg && !fire;
    assign accept    = evt_valid && !evt_stall;

    // entries as seen by the executing request
    assign e0 = fwd0_reg ? wd_reg : rd0_reg;
    assign e1 = fwd1_reg ? wd_reg : rd1_reg;

    assign fst.full      = (count_reg == FULL_CNT);
    assign fst.empty     = (count_reg == '0);
    assign fst.one_left  = (count_reg < CW'(2));
    assign fst.no_frames = (frames_reg == '0);

    i2cms_step u_step (
        .evt       (ex_evt_reg),
        .ctrl      (ctrl_reg),
        .fst       (fst),
        .e0        (e0),
        .e1        (e1),
        .ctrl_next (ctrl_next),
        .upd       (upd),
        .res       (step_res)
    );

    assign wr_en        = fire && upd.push;
    assign wr_data.last = upd.push_last;
    assign wr_data.data = ex_evt_reg.push_byte;

    assign head_adv1 = adv(head_reg);
    assign head_adv2 = adv(head_adv1);

    always_comb
    begin
        head_next = head_reg;
        if (fire)
        begin
            case (upd.pop_n)
                2'd1:    head_next = head_adv1;
                2'd2:    head_next = head_adv2;
                default: head_next = head_reg;
            endcase
        end
    end

    // next request reads the head left behind by the current one
    assign rd_addr0 = head_next;
    assign rd_addr1 = adv(head_next);

    assign count_next  = count_reg + CW'(upd.push) - CW'(upd.pop_n);
    assign frames_next = frames_reg + CW'(upd.push && upd.push_last) - CW'(upd.frame_dec);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[tail_reg] <= wr_data;
        if (accept)
        begin
            rd0_reg    <= mem[rd_addr0];
            rd1_reg    <= mem[rd_addr1];
            fwd0_reg   <= wr_en && (tail_reg == rd_addr0);
            fwd1_reg   <= wr_en && (tail_reg == rd_addr1);
            wd_reg     <= wr_data;
            ex_evt_reg <= evt;
        end
        if (fire)
            res_reg <= step_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            frames_reg    <= '0;
            ctrl_reg      <= '{phase: PH_IDLE, read_remaining: 8'd0,
                               frame_in_progress: 1'b0, halt_error: ERR_NONE};
            ex_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                head_reg   <= head_next;
                count_reg  <= count_next;
                frames_reg <= frames_next;
                ctrl_reg   <= ctrl_next;
                if (upd.push)
                    tail_reg <= adv(tail_reg);
            end
            if (accept)
                ex_valid_reg <= 1'b1;
            else if (fire)
                ex_valid_reg <= 1'b0;
            if (fire)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= FULL_CNT) && (frames_reg <= count_reg))
        else $error("FIFO count or frame count out of range");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.halt_error != ERR_NONE) |=> $stable(ctrl_reg.halt_error))
        else $error("halt code changed after halt");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        evt_stall |-> (res_valid && res_stall && ex_valid_reg))
        else $error("request stalled without a blocked result");

    a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.halted == (res.error_code != ERR_NONE)))
        else $error("halted flag disagrees with error code");
`endif

endmodule

// File: hdl/i2cms_step.sv
// Per-request decision logic of the I2C master sequencer: phase walk,
// command and incoming item, FIFO update. Depends on i2cms_pkg.
module i2cms_step
    import i2cms_pkg::*;
(
    input  evt_t   evt,
    input  ctrl_t  ctrl,
    input  fstat_t fst,
    input  entry_t e0,      // entry at head
    input  entry_t e1,      // entry after head
    output ctrl_t  ctrl_next,
    output fupd_t  upd,
    output res_t   res
);

    always_comb
    begin
        logic [7:0] left;
        logic [2:0] err;
        logic       do_write;
        logic       is_addr;

        left      = ctrl.read_remaining - 8'd1;
        err       = ERR_NONE;
        do_write  = 1'b0;
        is_addr   = 1'b0;
        ctrl_next = ctrl;
        upd       = '0;
        res       = '0;

        if (ctrl.halt_error != ERR_NONE)
        begin
            // halted: nothing moves
        end
        else if (evt.kind == KIND_PUSH)
        begin
            if (fst.full)
                err = ERR_OUT_FULL;
            else
            begin
                upd.push      = 1'b1;
                upd.push_last = evt.push_last;
            end
        end
        else if (evt.kind != KIND_EVENT)
        begin
            if (ctrl.phase == PH_IDLE && !fst.no_frames)
            begin
                res.command     = CMD_START;
                ctrl_next.phase = PH_START;
            end
        end
        else
        begin
            case (ctrl.phase)
                PH_START:
                begin
                    if (fst.no_frames || fst.empty)
                        err = ERR_OUT_EMPTY;
                    else
                    begin
                        do_write = 1'b1;
                        is_addr  = 1'b1;
                    end
                end
                PH_STOP:
                    ctrl_next.phase = PH_IDLE;
                PH_ACK_RCVD:
                begin
                    if (evt.ack_status)
                        err = ERR_NO_ACK;
                    else if (ctrl.read_remaining != 8'd0)
                    begin
                        res.command     = CMD_RCEN;
                        ctrl_next.phase = PH_BYTE_RCVD;
                    end
                    else if (fst.no_frames || !ctrl.frame_in_progress || fst.empty)
                    begin
                        res.command     = CMD_STOP;
                        ctrl_next.phase = PH_STOP;
                    end
                    else
                        do_write = 1'b1;
                end
                PH_BYTE_RCVD:
                begin
                    if (evt.rx_queue_full)
                        err = ERR_IN_FULL;
                    else
                    begin
                        ctrl_next.read_remaining = left;
                        res.rx_valid    = 1'b1;
                        res.rx_data     = evt.rx_byte;
                        res.rx_last     = (left == 8'd0);
                        res.command     = CMD_ACK;
                        res.send_nack   = (left == 8'd0);
                        ctrl_next.phase = PH_ACK_SENT;
                    end
                end
                PH_ACK_SENT:
                begin
                    if (ctrl.read_remaining != 8'd0)
                    begin
                        res.command     = CMD_RCEN;
                        ctrl_next.phase = PH_BYTE_RCVD;
                    end
                    else
                    begin
                        res.command     = CMD_STOP;
                        ctrl_next.phase = PH_STOP;
                    end
                end
                default:
                    err = ERR_BAD_STATE;
            endcase

            if (do_write)
            begin
                upd.pop_n     = 2'd1;
                upd.frame_dec = e0.last;
                ctrl_next.frame_in_progress = !e0.last;
                if (evt.write_collision)
                    err = ERR_COLLISION;
                else if (is_addr && e0.data[0])
                begin
                    // read frame: the length byte must follow and end it
                    if (e0.last || fst.one_left)
                        err = ERR_BAD_FRAME;
                    else
                    begin
                        upd.pop_n     = 2'd2;
                        upd.frame_dec = 1'b1;
                        if (!e1.last)
                            err = ERR_BAD_FRAME;
                        else
                        begin
                            ctrl_next.read_remaining    = e1.data;
                            ctrl_next.frame_in_progress = 1'b0;
                            if (evt.rx_queue_full)
                                err = ERR_IN_FULL;
                            else
                            begin
                                res.rx_valid      = 1'b1;
                                res.rx_data       = {1'b0, e0.data[7:1]};
                                res.rx_is_address = 1'b1;
                            end
                        end
                    end
                end
                if (err == ERR_NONE)
                begin
                    res.command     = CMD_TX;
                    res.tx_byte     = e0.data;
                    ctrl_next.phase = PH_ACK_RCVD;
                end
            end
        end

        // a fatal step only latches the code; later state no longer matters
        if (err != ERR_NONE)
        begin
            ctrl_next            = ctrl;
            ctrl_next.halt_error = err;
            upd                  = '0;
            res                  = '0;
        end

        res.error_code = ctrl_next.halt_error;
        res.halted     = (ctrl_next.halt_error != ERR_NONE);
    end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for i2c_master_transaction_sequencer: a directed request table,
// then state-aware random frames and bus events, all checked against an in-bench predictor.
// Depends on i2cms_pkg (hdl/i2cms_pkg.sv) and the RTL top level.
module tb_top;
    import i2cms_pkg::*;

    localparam int DEPTH         = 128;
    localparam int RAND_REQUESTS = 1550;
    localparam int HOLD_AT       = 500;   // random request count that triggers the long hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES  = 12;
    localparam int HALTED_TAIL   = 8;     // requests sent after the halt
    localparam int LONG_READ_AT  = 800;
    localparam int MAX_REPORTS   = 40;

    // unused kind code, decoded as a poll
    localparam logic [1:0] KIND_POLL_ALT = 2'd3;

    // how the run is driven into its fatal end
    localparam int FIN_RAW      = 0;  // unconstrained requests
    localparam int FIN_OVERFLOW = 1;  // push past a full FIFO
    localparam int FIN_ADDR_END = 2;  // read address carries the last mark
    localparam int FIN_LEN_OPEN = 3;  // read length byte without the last mark

    // receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_SPARSE   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_HEAVY    = 3;

    typedef struct {
        evt_t req;
        bit   quiet;  // expect the all-zero result
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic evt_valid;
    logic evt_stall;
    evt_t evt;
    logic res_valid;
    logic res_stall;
    res_t res;

    // predictor state
    entry_t     q_mem [DEPTH];
    int         q_rd;
    int         q_wr;
    int         q_count;
    int         q_frames;
    phase_t     bus_phase;
    logic [7:0] bytes_to_read;
    logic       mid_frame;
    logic [2:0] halt_code;

    res_t     expected_results [$];
    entry_t   frame_plan [$];
    dir_row_t dir_tab [$];

    int dir_pos;
    int rand_done;
    int tail_left;
    bit long_read_done;
    bit finale_armed;
    bit finale_lock;
    int finale_mode;
    bit hold_req;
    bit hold_done;
    int hold_left;

    int n_requests;
    int n_results;
    int n_tx;
    int n_rx;
    int n_fail;
    int n_reported;
    int quiet_cycles;

    i2c_master_transaction_sequencer #(.FIFO_DEPTH(DEPTH)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic entry_t fifo_take();
        entry_t e;
        e = q_mem[q_rd];
        q_rd = (q_rd + 1) % DEPTH;
        q_count--;
        if (e.last && q_frames > 0)
            q_frames--;
        return e;
    endfunction

    function automatic res_t predict_sequencer(evt_t r);
        res_t       o;
        entry_t     e;
        entry_t     l;
        logic [2:0] err;
        bit         do_pop;
        bit         addr_pop;
        o = '0;
        err = ERR_NONE;
        do_pop = 0;
        addr_pop = 0;
        if (halt_code != ERR_NONE)
        begin
            // halted: nothing moves
        end
        else if (r.kind == KIND_PUSH)
        begin
            if (q_count >= DEPTH)
                err = ERR_OUT_FULL;
            else
            begin
                q_mem[q_wr] = '{last: r.push_last, data: r.push_byte};
                q_wr = (q_wr + 1) % DEPTH;
                q_count++;
                if (r.push_last)
                    q_frames++;
            end
        end
        else if (r.kind != KIND_EVENT)
        begin
            if (bus_phase == PH_IDLE && q_frames > 0)
            begin
                o.command = CMD_START;
                bus_phase = PH_START;
            end
        end
        else
        begin
            case (bus_phase)
                PH_START:
                    if (q_frames == 0 || q_count == 0)
                        err = ERR_OUT_EMPTY;
                    else
                    begin
                        do_pop = 1;
                        addr_pop = 1;
                    end
                PH_STOP:
                    bus_phase = PH_IDLE;
                PH_ACK_RCVD:
                    if (r.ack_status)
                        err = ERR_NO_ACK;
                    else if (bytes_to_read != 8'd0)
                    begin
                        o.command = CMD_RCEN;
                        bus_phase = PH_BYTE_RCVD;
                    end
                    else if (q_frames == 0 || !mid_frame || q_count == 0)
                    begin
                        o.command = CMD_STOP;
                        bus_phase = PH_STOP;
                    end
                    else
                        do_pop = 1;
                PH_BYTE_RCVD:
                    if (r.rx_queue_full)
                        err = ERR_IN_FULL;
                    else
                    begin
                        bytes_to_read = bytes_to_read - 8'd1;
                        o.rx_valid = 1'b1;
                        o.rx_data = r.rx_byte;
                        o.rx_last = (bytes_to_read == 8'd0);
                        o.command = CMD_ACK;
                        o.send_nack = o.rx_last;
                        bus_phase = PH_ACK_SENT;
                    end
                PH_ACK_SENT:
                    if (bytes_to_read != 8'd0)
                    begin
                        o.command = CMD_RCEN;
                        bus_phase = PH_BYTE_RCVD;
                    end
                    else
                    begin
                        o.command = CMD_STOP;
                        bus_phase = PH_STOP;
                    end
                default:
                    err = ERR_BAD_STATE;
            endcase
            if (do_pop)
            begin
                e = fifo_take();
                mid_frame = !e.last;
                // collision wins over any frame check
                if (r.write_collision)
                    err = ERR_COLLISION;
                else if (addr_pop && e.data[0])
                begin
                    if (!mid_frame || q_count == 0)
                        err = ERR_BAD_FRAME;
                    else
                    begin
                        l = fifo_take();
                        if (!l.last)
                            err = ERR_BAD_FRAME;
                        else
                        begin
                            bytes_to_read = l.data;
                            mid_frame = 1'b0;
                            if (r.rx_queue_full)
                                err = ERR_IN_FULL;
                            else
                            begin
                                o.rx_valid = 1'b1;
                                o.rx_data = {1'b0, e.data[7:1]};
                                o.rx_is_address = 1'b1;
                            end
                        end
                    end
                end
                if (err == ERR_NONE)
                begin
                    o.command = CMD_TX;
                    o.tx_byte = e.data;
                    bus_phase = PH_ACK_RCVD;
                end
            end
        end
        if (err != ERR_NONE)
        begin
            halt_code = err;
            o = '0;
        end
        o.error_code = halt_code;
        o.halted = (halt_code != ERR_NONE);
        return o;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void dir_row(logic [1:0] k, logic [7:0] b, logic l, logic a,
                                    logic [7:0] x, logic w, logic f, bit quiet);
        dir_row_t row;
        row.req = '{kind: k, push_byte: b, push_last: l, ack_status: a, rx_byte: x,
                    write_collision: w, rx_queue_full: f};
        row.quiet = quiet;
        dir_tab.push_back(row);
    endfunction

    function automatic void load_directed();
        // after reset: nothing queued, polls do nothing
        dir_row(KIND_POLL,     8'h00, 0, 0, 8'h00, 0, 0, 1);
        dir_row(KIND_POLL_ALT, 8'hFF, 1, 1, 8'hFF, 1, 1, 1);
        // two-byte write frame
        dir_row(KIND_PUSH,     8'hA4, 0, 0, 8'h00, 0, 0, 1);
        dir_row(KIND_PUSH,     8'hFF, 1, 0, 8'h00, 0, 0, 1);
        dir_row(KIND_POLL,     8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        // stop phase ignores every flag
        dir_row(KIND_EVENT,    8'h00, 0, 1, 8'hFF, 1, 1, 0);
        // zero-length read from the top address
        dir_row(KIND_PUSH,     8'hFF, 0, 0, 8'h00, 0, 0, 1);
        dir_row(KIND_PUSH,     8'h00, 1, 0, 8'h00, 0, 0, 1);
        dir_row(KIND_POLL,     8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        // two-byte read from address zero
        dir_row(KIND_PUSH,     8'h01, 0, 0, 8'h00, 0, 0, 1);
        dir_row(KIND_PUSH,     8'h02, 1, 0, 8'h00, 0, 0, 1);
        dir_row(KIND_POLL,     8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'hFF, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
        dir_row(KIND_EVENT,    8'h00, 0, 0, 8'h00, 0, 0, 0);
    endfunction

    function automatic evt_t raw_request();
        evt_t q;
        q.kind = 2'($urandom_range(0, 3));
        q.push_byte = 8'($urandom_range(0, 255));
        q.push_last = 1'($urandom_range(0, 1));
        q.ack_status = 1'($urandom_range(0, 1));
        q.rx_byte = 8'($urandom_range(0, 255));
        q.write_collision = 1'($urandom_range(0, 1));
        q.rx_queue_full = 1'($urandom_range(0, 1));
        return q;
    endfunction

    // Queue up one well-formed frame, only if all of it fits: a partial frame
    // stuck in a full FIFO would block the sequencer for good.
    function automatic void plan_frame();
        int         room;
        int         n;
        int         sel;
        logic [7:0] addr;
        logic [7:0] len;
        room = DEPTH - q_count;
        addr = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 6)
        begin
            if (sel < 4)
                n = room - 1;               // fills the FIFO to the brim
            else if (sel < 12)
                n = $urandom_range(7, 40);
            else
                n = $urandom_range(0, 6);
            if (n < 0 || n + 1 > room)
                return;
            frame_plan.push_back('{last: (n == 0), data: {addr[7:1], 1'b0}});
            for (int i = 0; i < n; i++)
                frame_plan.push_back('{last: (i == n - 1), data: 8'($urandom_range(0, 255))});
        end
        else
        begin
            if (room < 2)
                return;
            if (!long_read_done && rand_done > LONG_READ_AT)
            begin
                len = 8'hFF;
                long_read_done = 1;
            end
            else if (sel < 8)
                len = 8'h00;
            else if (sel < 15)
                len = 8'($urandom_range(6, 30));
            else
                len = 8'($urandom_range(1, 5));
            frame_plan.push_back('{last: 1'b0, data: {addr[7:1], 1'b1}});
            frame_plan.push_back('{last: 1'b1, data: len});
        end
    endfunction

    // Random request that keeps the transaction legal: flags that would halt
    // the block are cleared only in the phases where they matter.
    function automatic evt_t random_request();
        evt_t        q;
        entry_t      e;
        int unsigned r;
        q = raw_request();
        r = $urandom_range(0, 99);
        if (frame_plan.size() == 0 && r < 30 && !finale_lock)
            plan_frame();
        if (frame_plan.size() != 0 && (r < 35 || (bus_phase == PH_IDLE && q_frames == 0)))
        begin
            e = frame_plan.pop_front();
            q.kind = KIND_PUSH;
            q.push_byte = e.data;
            q.push_last = e.last;
        end
        else if (bus_phase == PH_IDLE || r >= 88)
            q.kind = $urandom_range(0, 1) ? KIND_POLL : KIND_POLL_ALT;
        else
        begin
            q.kind = KIND_EVENT;
            case (bus_phase)
                PH_START:
                begin
                    q.write_collision = 1'b0;
                    q.rx_queue_full = 1'b0;
                end
                PH_ACK_RCVD:
                begin
                    q.ack_status = 1'b0;
                    q.write_collision = 1'b0;
                end
                PH_BYTE_RCVD:
                    q.rx_queue_full = 1'b0;
                default:
                    ;
            endcase
        end
        return q;
    endfunction

    // Drives the block into one fatal error, picked by the seed.
    function automatic evt_t finale_request();
        evt_t       q;
        logic [7:0] addr;
        if (!finale_armed)
        begin
            finale_armed = 1;
            finale_mode = $urandom_range(FIN_RAW, FIN_LEN_OPEN);
        end
        case (finale_mode)
            FIN_OVERFLOW:
            begin
                q = raw_request();
                q.kind = KIND_PUSH;
            end
            FIN_ADDR_END, FIN_LEN_OPEN:
            begin
                if (!finale_lock && frame_plan.size() == 0 && q_count + 3 <= DEPTH)
                begin
                    finale_lock = 1;
                    addr = {7'($urandom_range(0, 127)), 1'b1};
                    if (finale_mode == FIN_ADDR_END)
                        frame_plan.push_back('{last: 1'b1, data: addr});
                    else
                    begin
                        frame_plan.push_back('{last: 1'b0, data: addr});
                        frame_plan.push_back('{last: 1'b0, data: 8'($urandom_range(0, 255))});
                        frame_plan.push_back('{last: 1'b1, data: 8'($urandom_range(0, 255))});
                    end
                end
                q = random_request();
            end
            default:
                q = raw_request();
        endcase
        return q;
    endfunction

    // Picks the next request, runs it through the predictor and queues the
    // expected result. Returns 0 when the stimulus is exhausted.
    function automatic bit next_request(output evt_t q);
        res_t want;
        bit   quiet;
        bit   counts;
        quiet = 0;
        counts = 0;
        if (dir_pos < dir_tab.size())
        begin
            q = dir_tab[dir_pos].req;
            quiet = dir_tab[dir_pos].quiet;
            dir_pos++;
        end
        else if (rand_done < RAND_REQUESTS)
        begin
            q = random_request();
            counts = 1;
        end
        else if (halt_code == ERR_NONE)
            q = finale_request();
        else if (tail_left > 0)
        begin
            q = raw_request();
            tail_left--;
        end
        else
            return 0;
        want = predict_sequencer(q);
        if (counts)
        begin
            rand_done++;
            if (rand_done == HOLD_AT)
                hold_req = 1;
        end
        expected_results.push_back(quiet ? res_t'('0) : want);
        return 1;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            if (n_reported < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_reported++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void check_result(res_t got);
        res_t want;
        bit   ok;
        n_results++;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result with nothing expected, actual %h", $time, got);
            n_fail++;
            return;
        end
        want = expected_results.pop_front();
        ok = 1;
        ok &= field_ok("command", 8'(want.command), 8'(got.command));
        ok &= field_ok("tx_byte", want.tx_byte, got.tx_byte);
        ok &= field_ok("send_nack", 8'(want.send_nack), 8'(got.send_nack));
        ok &= field_ok("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
        ok &= field_ok("rx_data", want.rx_data, got.rx_data);
        ok &= field_ok("rx_is_address", 8'(want.rx_is_address), 8'(got.rx_is_address));
        ok &= field_ok("rx_last", 8'(want.rx_last), 8'(got.rx_last));
        ok &= field_ok("error_code", 8'(want.error_code), 8'(got.error_code));
        ok &= field_ok("halted", 8'(want.halted), 8'(got.halted));
        if (!ok)
            n_fail++;
        if (got.command == CMD_TX)
            n_tx++;
        if (got.rx_valid === 1'b1 && got.rx_is_address === 1'b0)
            n_rx++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
            check_result(res);
    end

    // no transfer on either channel for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial
    begin : receiver
        int mode;
        int seg_left;
        int tick;
        bit stall;
        mode = RX_FREE;
        seg_left = 0;
        tick = 0;
        res_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall = 1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(RX_FREE, RX_HEAVY);
                    seg_left = $urandom_range(16, 120);
                end
                seg_left--;
                tick++;
                case (mode)
                    RX_FREE:     stall = 0;
                    RX_SPARSE:   stall = ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: stall = ((tick % 7) < 3);
                    default:     stall = ($urandom_range(0, 1) == 1);
                endcase
            end
            res_stall <= stall;
        end
    end

    // ---------------------------------------------------------------- sender

    initial
    begin : sender
        evt_t item;
        int   burst_left;
        int   gap;
        burst_left = 0;
        evt_valid = 1'b0;
        evt = '0;
        rst_n = 1'b0;
        q_rd = 0;
        q_wr = 0;
        q_count = 0;
        q_frames = 0;
        bus_phase = PH_IDLE;
        bytes_to_read = 8'd0;
        mid_frame = 1'b0;
        halt_code = ERR_NONE;
        tail_left = HALTED_TAIL;
        load_directed();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (next_request(item))
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                // keep offering while the receiver holds off
                gap = ($urandom_range(0, 3) == 0 || hold_left > 0) ? 0 : $urandom_range(1, 24);
                if (gap > 0)
                begin
                    evt_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            evt_valid <= 1'b1;
            evt <= item;
            do
                @(posedge clk);
            while (evt_stall);
            n_requests++;
        end
        evt_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests (%0d directed), %0d results, %0d bytes sent, %0d read",
                 n_requests, dir_tab.size(), n_results, n_tx, n_rx);
        $display("Run ended halted with code %0d, %0d failing results", halt_code, n_fail);
        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
